FILE: hw/rtl/tcb_pkg.sv
// Shared types and constants for the text cell buffer.
`timescale 1ns / 1ps

package tcb_pkg;

	// Command codes carried on the command field
	typedef enum logic [2:0] {
		CMD_PUT    = 3'd0,
		CMD_GET    = 3'd1,
		CMD_SCROLL = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_CURSOR = 3'd4
	} cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_CLEAR
	} state_t;

	localparam logic [7:0]  BLANK_CHAR = 8'h20;
	localparam logic [7:0]  CLEAR_ATTR = 8'h07;
	localparam logic [15:0] CLEAR_CELL = {CLEAR_ATTR, BLANK_CHAR};

endpackage

FILE: hw/rtl/tcb_ram.sv
// Simple dual-port cell memory: one write port, one registered read port.
`timescale 1ns / 1ps

module tcb_ram #(
	parameter int DEPTH = 2000,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wa,
	input  logic [WIDTH-1:0] wd,
	input  logic             re,
	input  logic [AW-1:0]    ra,
	output logic [WIDTH-1:0] rd
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// Read one entry, data valid the next cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rd <= mem[ra];
		end
	end

endmodule

FILE: hw/rtl/text_cell_buffer_scroll_clear.sv
// Text-mode cell buffer top level: command sequencer, cursor and result register.
// Result registered in the cycle after acceptance; on-screen get: after the memory read.
// Put and set-cursor: one transaction per cycle while results drain; input is held off
// while an on-screen get read is pending and while a scroll or clear runs,
// one memory cell per cycle through the single read and single write port.
// Reset clears control state, then a pass over every cell zeroes the memory
// before the first transaction is accepted.
`timescale 1ns / 1ps

module text_cell_buffer_scroll_clear
	import tcb_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [7:0]  col,
	input  logic [7:0]  row,
	input  logic [7:0]  character,
	input  logic [7:0]  attribute,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] cell_value,
	output logic [15:0] cursor_position,
	output logic        in_range
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW = $clog2(CELLS);
	localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] COL_STEP = AW'(COLUMNS);

	state_t state_q, state_d;
	logic [AW-1:0] cnt_q;
	logic          sweep_end;

	logic          sc_vld_s1;
	logic [AW-1:0] sc_wa_s1;
	logic          sc_blank_s1;
	logic          rd_pend_s1;

	logic [15:0] cursor_q;
	logic        out_valid_q;
	logic [15:0] cell_value_q;
	logic [15:0] cursor_out_q;
	logic        in_range_q;

	logic [15:0]   lin;
	logic          on_screen;
	logic [AW-1:0] cell_idx;
	logic          accept;
	cmd_t          cmd;
	logic          get_hit;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [15:0]   mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;
	logic [15:0]   mem_rd;

	// Decode the incoming transaction
	assign cmd = cmd_t'(command);
	assign lin = 16'(16'(row) * 16'(COLUMNS)) + 16'(col);
	assign on_screen = (col < 8'(COLUMNS)) && (row < 8'(ROWS));
	assign cell_idx = lin[AW-1:0];
	assign sweep_end = (cnt_q == LAST_IDX);

	// Take a transaction only when idle, nothing in flight and the result slot frees up
	assign in_ready = (state_q == ST_IDLE) && !rd_pend_s1 && !sc_vld_s1
		&& (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;
	assign get_hit = accept && (cmd == CMD_GET) && on_screen;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sweep_end) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && cmd == CMD_SCROLL) state_d = ST_SCROLL;
				else if (accept && cmd == CMD_CLEAR) state_d = ST_CLEAR;
			end
			ST_SCROLL, ST_CLEAR: begin
				if (sweep_end) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cell_idx;
		mem_wd = {attribute, character};
		mem_re = 1'b0;
		mem_ra = cell_idx;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = '0;
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = CLEAR_CELL;
			end
			ST_SCROLL: begin
				mem_re = 1'b1;
				mem_ra = (cnt_q < LAST_BASE) ? cnt_q + COL_STEP : cnt_q;
			end
			ST_IDLE: begin
				mem_we = accept && (cmd == CMD_PUT) && on_screen;
				mem_re = get_hit;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
		// Scroll write-back, in the cycle after its read
		if (sc_vld_s1) begin
			mem_we = 1'b1;
			mem_wa = sc_wa_s1;
			mem_wd = sc_blank_s1 ? {mem_rd[15:8], BLANK_CHAR} : mem_rd;
		end
	end

	// State, sweep counter and in-flight flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q <= '0;
			sc_vld_s1 <= 1'b0;
			rd_pend_s1 <= 1'b0;
			cursor_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != ST_IDLE) begin
				cnt_q <= sweep_end ? '0 : cnt_q + 1'b1;
			end
			sc_vld_s1 <= (state_q == ST_SCROLL);
			rd_pend_s1 <= get_hit;
			if (accept && cmd == CMD_CURSOR) begin
				cursor_q <= lin;
			end
		end
	end

	// Scroll pipeline payload
	always_ff @(posedge clk) begin
		sc_wa_s1 <= cnt_q;
		sc_blank_s1 <= (cnt_q >= LAST_BASE);
	end

	// Result valid: load on a finished transaction, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !get_hit) || rd_pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			cell_value_q <= mem_rd;
			cursor_out_q <= cursor_q;
			in_range_q <= 1'b1;
		end else if (accept && !get_hit) begin
			cell_value_q <= '0;
			cursor_out_q <= (cmd == CMD_CURSOR) ? lin : cursor_q;
			in_range_q <= (cmd == CMD_PUT) && on_screen;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_value = cell_value_q;
	assign cursor_position = cursor_out_q;
	assign in_range = in_range_q;

	tcb_ram #(
		.DEPTH(CELLS),
		.WIDTH(16)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.wa(mem_wa),
		.wd(mem_wd),
		.re(mem_re),
		.ra(mem_ra),
		.rd(mem_rd)
	);

	// No transaction may slip in while a scroll write-back is pending
	a_no_accept_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		sc_vld_s1 |-> !(in_valid && in_ready))
		else $error("transaction accepted during scroll write-back");

	// A pending get delivers its result on the next edge
	a_get_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |=> out_valid_q)
		else $error("get result not loaded");

	// The last scroll read is followed by its write-back and return to idle
	a_scroll_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && sweep_end) |=> (sc_vld_s1 && state_q == ST_IDLE))
		else $error("scroll did not finish cleanly");

	// Read and write never touch the same cell during a scroll
	a_scroll_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(sc_vld_s1 && mem_re) |-> (mem_wa != mem_ra))
		else $error("scroll read and write collide");

endmodule

FILE: dv/cell_buffer_checker.sv
// Transaction monitor, screen predictor and result comparison for the text cell buffer.
`timescale 1ns / 1ps

module cell_buffer_checker
	import tcb_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  command,
	input  logic [7:0]  col,
	input  logic [7:0]  row,
	input  logic [7:0]  character,
	input  logic [7:0]  attribute,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] cell_value,
	input  logic [15:0] cursor_position,
	input  logic        in_range,
	output int          errors,
	output int          pending
);

	localparam int CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [15:0] cursor_position;
		logic        in_range;
	} screen_result_t;

	logic [15:0]    shadow_cells [CELLS];
	logic [15:0]    shadow_cursor = '0;
	screen_result_t awaited_results [$];
	int             mismatch_count = 0;
	int             awaited_count = 0;

	assign errors = mismatch_count;
	assign pending = awaited_count;

	// Apply one command to the shadow screen and return the result it owes
	function automatic screen_result_t run_screen_command(logic [2:0] cmd, logic [7:0] c,
			logic [7:0] r, logic [7:0] ch, logic [7:0] at);
		screen_result_t res;
		int             linear;
		bit             on_screen;
		res = '0;
		linear = int'(r) * COLUMNS + int'(c);
		on_screen = (int'(c) < COLUMNS) && (int'(r) < ROWS);
		case (cmd)
			CMD_PUT: begin
				if (on_screen) begin
					shadow_cells[linear] = {at, ch};
					res.in_range = 1'b1;
				end
			end
			CMD_GET: begin
				if (on_screen) begin
					res.cell_value = shadow_cells[linear];
					res.in_range = 1'b1;
				end
			end
			CMD_SCROLL: begin
				// Move every row up by one, then blank the bottom row keeping attributes
				for (int i = 0; i < CELLS - COLUMNS; i++)
					shadow_cells[i] = shadow_cells[i + COLUMNS];
				for (int i = CELLS - COLUMNS; i < CELLS; i++)
					shadow_cells[i] = {shadow_cells[i][15:8], BLANK_CHAR};
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					shadow_cells[i] = CLEAR_CELL;
			end
			CMD_CURSOR: begin
				// No range check on the cursor; keep the low 16 bits
				shadow_cursor = 16'(linear);
			end
			default: begin
			end
		endcase
		res.cursor_position = shadow_cursor;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		screen_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				shadow_cells[i] = '0;
			shadow_cursor = '0;
			awaited_results.delete();
		end else begin
			// Compare the result transaction with the oldest expectation
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: cell_value %h cursor_position %h in_range %b",
						cell_value, cursor_position, in_range);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					if (cell_value !== want.cell_value) begin
						$error("cell_value: expected %h, actual %h", want.cell_value, cell_value);
						mismatch_count++;
					end
					if (cursor_position !== want.cursor_position) begin
						$error("cursor_position: expected %h, actual %h",
							want.cursor_position, cursor_position);
						mismatch_count++;
					end
					if (in_range !== want.in_range) begin
						$error("in_range: expected %b, actual %b", want.in_range, in_range);
						mismatch_count++;
					end
				end
			end
			// Predict the result of an accepted command transaction
			if (in_valid && in_ready)
				awaited_results.push_back(run_screen_command(command, col, row, character,
					attribute));
		end
		awaited_count = awaited_results.size();
	end

endmodule

FILE: dv/testbench.sv
// Top of the text cell buffer testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module testbench
	import tcb_pkg::*;
();

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int RANDOM_COMMANDS = 1900;
	localparam int SLOW_COMMAND_CAP = 80;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 10;
	localparam int MAX_WAIT = 10;
	localparam int STEADY_SPAN = 64;
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
	localparam logic [7:0] LAST_COL = 8'(COLUMNS - 1);
	localparam logic [7:0] LAST_ROW = 8'(ROWS - 1);
	localparam logic [7:0] OFF_COL = 8'(COLUMNS);
	localparam logic [7:0] OFF_ROW = 8'(ROWS);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  command = '0;
	logic [7:0]  col = '0;
	logic [7:0]  row = '0;
	logic [7:0]  character = '0;
	logic [7:0]  attribute = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] cell_value;
	logic [15:0] cursor_position;
	logic        in_range;
	int          errors;
	int          pending;
	int          cycle_count = 0;
	int          slow_commands = 0;
	bit          sender_steady = 1'b0;
	bit          receiver_steady = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk) cycle_count++;

	text_cell_buffer_scroll_clear #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.col(col),
		.row(row),
		.character(character),
		.attribute(attribute),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_value(cell_value),
		.cursor_position(cursor_position),
		.in_range(in_range)
	);

	cell_buffer_checker #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) cell_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.col(col),
		.row(row),
		.character(character),
		.attribute(attribute),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_value(cell_value),
		.cursor_position(cursor_position),
		.in_range(in_range),
		.errors(errors),
		.pending(pending)
	);

	// Offer one command transaction after a random gap (none while the sender is steady) and hold it until accepted
	task automatic issue(input logic [2:0] cmd, input logic [7:0] c, r, ch, at);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(MAX_WAIT, 0);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		col <= c;
		row <= r;
		character <= ch;
		attribute <= at;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (cmd == CMD_SCROLL || cmd == CMD_CLEAR)
			slow_commands++;
		@(negedge clk);
	endtask

	// Hold off new commands until every outstanding result has been returned
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// Choose a cell: any byte pair, the screen edge, a small area at the bottom left, or anywhere on screen
	task automatic pick_cell(output logic [7:0] c, r);
		case ($urandom_range(9, 0))
			0: begin
				c = 8'($urandom_range(255, 0));
				r = 8'($urandom_range(255, 0));
			end
			1: begin
				c = 8'($urandom_range(COLUMNS, COLUMNS - 1));
				r = 8'($urandom_range(ROWS, ROWS - 1));
			end
			2, 3, 4: begin
				c = 8'($urandom_range(7, 0));
				r = 8'($urandom_range(ROWS - 1, ROWS - 4));
			end
			default: begin
				c = 8'($urandom_range(COLUMNS - 1, 0));
				r = 8'($urandom_range(ROWS - 1, 0));
			end
		endcase
	endtask

	// Stop the run if it hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("testbench: done, errors");
		$finish;
	end

	// Drain results with random back-pressure, with stretches of steady ready
	initial begin
		int stall;
		int taken;
		taken = 0;
		while (!arst_n) @(negedge clk);
		forever begin
			if (taken % STEADY_SPAN == 0)
				receiver_steady = ($urandom_range(3, 0) == 0);
			stall = receiver_steady ? 0 : $urandom_range(MAX_WAIT, 0);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		logic [2:0] cmd;
		logic [7:0] c;
		logic [7:0] r;
		logic [7:0] ch;
		logic [7:0] at;
		int         draw;
		int         counted;
		int         offered;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset contents, corners, off-screen accesses, scroll, cursor, spare codes, clear
		issue(CMD_GET, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_PUT, 8'h00, 8'h00, 8'h00, 8'hFF);
		issue(CMD_PUT, LAST_COL, LAST_ROW, 8'hFF, 8'h00);
		issue(CMD_PUT, OFF_COL, 8'h00, 8'h55, 8'hAA);
		issue(CMD_PUT, 8'h00, OFF_ROW, 8'hAA, 8'h55);
		issue(CMD_PUT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		issue(CMD_GET, 8'h00, 8'h00, 8'hFF, 8'hFF);
		issue(CMD_GET, LAST_COL, LAST_ROW, 8'h00, 8'h00);
		issue(CMD_GET, OFF_COL, 8'h00, 8'h00, 8'h00);
		issue(CMD_GET, 8'h00, OFF_ROW, 8'h00, 8'h00);
		issue(CMD_GET, 8'hFF, 8'hFF, 8'h00, 8'h00);
		issue(CMD_PUT, 8'h05, 8'h01, 8'h41, 8'h1E);
		issue(CMD_SCROLL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		issue(CMD_GET, 8'h05, 8'h00, 8'h00, 8'h00);
		issue(CMD_GET, LAST_COL, LAST_ROW - 8'd1, 8'h00, 8'h00);
		issue(CMD_GET, LAST_COL, LAST_ROW, 8'h00, 8'h00);
		issue(CMD_CURSOR, 8'h00, 8'h00, 8'hFF, 8'hFF);
		issue(CMD_CURSOR, 8'hFF, 8'hFF, 8'h00, 8'h00);
		issue(CMD_CURSOR, LAST_COL, LAST_ROW, 8'h00, 8'h00);
		issue(CMD_SPARE_FIRST, 8'h00, 8'h00, 8'h41, 8'h07);
		issue(CMD_SPARE_MID, 8'h01, 8'h01, 8'h42, 8'h07);
		issue(CMD_SPARE_LAST, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		issue(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_GET, 8'd40, 8'd12, 8'h00, 8'h00);
		issue(CMD_SCROLL, 8'h00, 8'h00, 8'h00, 8'h00);
		drain_results();
		issue(CMD_GET, 8'h00, LAST_ROW, 8'h00, 8'h00);

		// Random: mostly puts and gets on the screen, some cursor and spare codes, occasional scroll and clear
		counted = 0;
		offered = 0;
		while (counted < RANDOM_COMMANDS) begin
			if (offered % STEADY_SPAN == 0)
				sender_steady = ($urandom_range(3, 0) == 0);
			offered++;
			pick_cell(c, r);
			ch = 8'($urandom_range(255, 0));
			at = 8'($urandom_range(255, 0));
			draw = $urandom_range(99, 0);
			if (draw < 42)
				cmd = CMD_PUT;
			else if (draw < 80)
				cmd = CMD_GET;
			else if (draw < 90)
				cmd = CMD_CURSOR;
			else if (draw < 96)
				cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
			else if (slow_commands >= SLOW_COMMAND_CAP)
				cmd = CMD_GET;
			else if (draw < 98)
				cmd = CMD_SCROLL;
			else
				cmd = CMD_CLEAR;
			issue(cmd, c, r, ch, at);
			if (cmd < CMD_SPARE_FIRST)
				counted++;
			if ($urandom_range(99, 0) == 0)
				drain_results();
		end

		// Wait for the last results, then let the block settle
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
